[rtl/core/bgr24_preview_mono_upscale2x_defines.svh]
// Assertion helpers shared by the core RTL.
`ifndef BGR24_PREVIEW_MONO_UPSCALE2X_DEFINES_SVH
`define BGR24_PREVIEW_MONO_UPSCALE2X_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BPMU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bpmu same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BPMU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bpmu next-cycle check failed");

`endif

[rtl/core/bpmu_pkg.sv]
package bpmu_pkg;

    localparam int IMG_WIDTH      = 128;
    localparam int IMG_HEIGHT     = 128;
    localparam int CHUNK_PIXELS   = 16;
    localparam int CHUNKS_PER_ROW = IMG_WIDTH / CHUNK_PIXELS;

    localparam int PIX_W = (CHUNK_PIXELS > 1) ? $clog2(CHUNK_PIXELS) : 1;
    localparam int CHK_W = (CHUNKS_PER_ROW > 1) ? $clog2(CHUNKS_PER_ROW) : 1;
    localparam int ROW_W = (IMG_HEIGHT > 1) ? $clog2(IMG_HEIGHT) : 1;
    localparam int ADDR_W = PIX_W + 1;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    localparam logic [PIX_W-1:0] LAST_POS   = PIX_W'(CHUNK_PIXELS - 1);
    localparam logic [CHK_W-1:0] LAST_CHUNK = CHK_W'(CHUNKS_PER_ROW - 1);
    localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(IMG_HEIGHT - 1);

    localparam logic [7:0] THRESHOLD_RESET = 8'd200;

    localparam logic CFG_THRESHOLD  = 1'b0;
    localparam logic CFG_COLOR_MODE = 1'b1;

    localparam logic [15:0] PIX_WHITE = 16'hFFFF;
    localparam logic [15:0] PIX_BLACK = 16'h0000;

    // one finished chunk waiting for its burst
    typedef struct packed {
        logic             bank;
        logic [CHK_W-1:0] chunk;
        logic [ROW_W-1:0] row;
    } t_desc;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       data;
    } t_wr_req;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

endpackage

[rtl/core/bgr24_preview_mono_upscale2x.sv]
// BGR24 to mono/RGB565 converter with 2x upscale. Source pixels arrive in
// raster order, one per request, and are converted on entry (threshold or
// RGB565, using the mode set at that moment) into one of two 16-pixel chunk
// buffers. Completing a chunk queues it for the back end, which emits 64
// results at up to one per cycle: two scanlines, each pixel doubled, with
// last_in_run on the final one. Each input pixel yields four results
// through the single output port; input is taken at one pixel per cycle
// while a free chunk buffer exists, and stalls when both buffers wait for
// their bursts. Chunks are popped only between bursts. The chunk buffers
// hold no defined value after reset and need no clearing pass.
module bgr24_preview_mono_upscale2x (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_red,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_pixel_color,
    output logic [7:0]  o_out_row,
    output logic [7:0]  o_out_col,
    output logic        o_last_in_run
);
    import bpmu_pkg::*;

    t_wr_req  w_wr;
    logic     w_push;
    t_desc    w_push_desc;
    logic     w_q_valid;
    t_desc    w_q_desc;
    logic     w_pop;
    t_release w_release;

    bpmu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_blue     (i_blue),
        .i_green    (i_green),
        .i_red      (i_red),
        .o_wr       (w_wr),
        .o_push     (w_push),
        .o_desc     (w_push_desc),
        .i_release  (w_release)
    );

    bpmu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_push_desc),
        .o_valid (w_q_valid),
        .o_desc  (w_q_desc),
        .i_pop   (w_pop)
    );

    bpmu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (w_wr),
        .i_q_valid     (w_q_valid),
        .i_q_desc      (w_q_desc),
        .o_pop         (w_pop),
        .o_release     (w_release),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_color (o_pixel_color),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_last_in_run (o_last_in_run)
    );

endmodule

[rtl/core/bpmu_front.sv]
`include "bgr24_preview_mono_upscale2x_defines.svh"

module bpmu_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_blue,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_red,
    output bpmu_pkg::t_wr_req  o_wr,
    output logic               o_push,
    output bpmu_pkg::t_desc    o_desc,
    input  bpmu_pkg::t_release i_release
);
    import bpmu_pkg::*;

    logic [7:0]       r_threshold;
    logic             r_color_mode;
    logic [PIX_W-1:0] r_pos;
    logic [CHK_W-1:0] r_chunk;
    logic [ROW_W-1:0] r_row;
    logic             r_wr_bank;
    logic [1:0]       r_bank_busy;

    logic             w_accept;
    logic             w_last;
    logic [9:0]       w_sum;
    logic [9:0]       w_limit;
    logic [15:0]      w_pixel;

    assign o_ready  = !r_bank_busy[r_wr_bank];
    assign w_accept = i_valid && o_ready;
    assign w_last   = (r_pos == LAST_POS);

    assign w_sum   = 10'(i_blue) + 10'(i_green) + 10'(i_red);
    assign w_limit = 10'(r_threshold) + {1'b0, r_threshold, 1'b0};

    always_comb begin
        if (r_color_mode) begin
            w_pixel = {i_red[7:3], i_green[7:2], i_blue[7:3]};
        end else if (w_sum > w_limit) begin
            w_pixel = PIX_WHITE;
        end else begin
            w_pixel = PIX_BLACK;
        end
    end

    assign o_wr.en   = w_accept;
    assign o_wr.addr = {r_wr_bank, r_pos};
    assign o_wr.data = w_pixel;

    assign o_push       = w_accept && w_last;
    assign o_desc.bank  = r_wr_bank;
    assign o_desc.chunk = r_chunk;
    assign o_desc.row   = r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THRESHOLD_RESET;
            r_color_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESHOLD:  r_threshold  <= i_cfg_data;
                CFG_COLOR_MODE: r_color_mode <= i_cfg_data[0];
                default:        r_threshold  <= r_threshold;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_chunk     <= '0;
            r_row       <= '0;
            r_wr_bank   <= 1'b0;
            r_bank_busy <= 2'b00;
        end else begin
            if (i_release.valid) begin
                r_bank_busy[i_release.bank] <= 1'b0;
            end
            if (w_accept) begin
                if (w_last) begin
                    // hand the full bank to the back end and switch banks
                    r_pos                  <= '0;
                    r_bank_busy[r_wr_bank] <= 1'b1;
                    r_wr_bank              <= !r_wr_bank;
                    if (r_chunk == LAST_CHUNK) begin
                        r_chunk <= '0;
                        r_row   <= (r_row == LAST_ROW) ? '0 : r_row + 1'b1;
                    end else begin
                        r_chunk <= r_chunk + 1'b1;
                    end
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end
        end
    end

    `BPMU_ASSERT_NEXT(a_bank_locked, i_clk, i_rst_n, w_accept && w_last, r_bank_busy[$past(r_wr_bank)])
    `BPMU_ASSERT_NOW(a_no_accept_full, i_clk, i_rst_n, r_bank_busy == 2'b11, !o_ready)

endmodule

[rtl/core/bpmu_queue.sv]
module bpmu_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bpmu_pkg::t_desc i_desc,
    output logic            o_valid,
    output bpmu_pkg::t_desc o_desc,
    input  logic            i_pop
);
    import bpmu_pkg::*;

    t_desc      r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_desc  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[rtl/core/bpmu_back.sv]
`include "bgr24_preview_mono_upscale2x_defines.svh"

module bpmu_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bpmu_pkg::t_wr_req  i_wr,
    input  logic               i_q_valid,
    input  bpmu_pkg::t_desc    i_q_desc,
    output logic               o_pop,
    output bpmu_pkg::t_release o_release,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_pixel_color,
    output logic [7:0]         o_out_row,
    output logic [7:0]         o_out_col,
    output logic               o_last_in_run
);
    import bpmu_pkg::*;

    logic [15:0]      r_mem [MEM_DEPTH];

    // burst sequencer
    logic             r_busy;
    logic             r_bank;
    logic [7:0]       r_col_base;
    logic [ROW_W-1:0] r_row;
    logic             r_scan;
    logic [PIX_W-1:0] r_m;
    logic             r_copy;

    // read stage
    logic             r_s1_valid;
    logic [15:0]      r_rd_data;
    logic [7:0]       r_s1_row;
    logic [7:0]       r_s1_col;
    logic             r_s1_last;

    // output register
    logic             r_out_valid;
    logic [15:0]      r_out_pixel;
    logic [7:0]       r_out_row;
    logic [7:0]       r_out_col;
    logic             r_out_last;

    logic             w_out_free;
    logic             w_s1_move;
    logic             w_load;
    logic             w_m_last;
    logic             w_gen_last;
    logic [7:0]       w_colsum;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign w_load     = r_busy && (!r_s1_valid || w_s1_move);
    assign w_m_last   = (r_m == LAST_POS);
    assign w_gen_last = r_scan && w_m_last && r_copy;
    assign w_colsum   = r_col_base + 8'(r_m);

    assign o_pop           = !r_busy && i_q_valid;
    assign o_release.valid = w_load && w_gen_last;
    assign o_release.bank  = r_bank;

    assign o_valid       = r_out_valid;
    assign o_pixel_color = r_out_pixel;
    assign o_out_row     = r_out_row;
    assign o_out_col     = r_out_col;
    assign o_last_in_run = r_out_last;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (w_load) begin
            r_rd_data <= r_mem[{r_bank, r_m}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bank     <= i_q_desc.bank;
            r_col_base <= 8'(i_q_desc.chunk * CHUNK_PIXELS);
            r_row      <= i_q_desc.row;
        end
        if (w_load) begin
            r_s1_row  <= 8'({r_row, r_scan});
            r_s1_col  <= {w_colsum[6:0], r_copy};
            r_s1_last <= w_gen_last;
        end
        if (w_s1_move) begin
            r_out_pixel <= r_rd_data;
            r_out_row   <= r_s1_row;
            r_out_col   <= r_s1_col;
            r_out_last  <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_scan      <= 1'b0;
            r_m         <= '0;
            r_copy      <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_scan <= 1'b0;
                r_m    <= '0;
                r_copy <= 1'b0;
            end else if (w_load) begin
                // advance copy, then pixel, then scanline
                r_copy <= !r_copy;
                if (r_copy) begin
                    if (w_m_last) begin
                        r_m    <= '0;
                        r_scan <= !r_scan;
                        if (r_scan) begin
                            r_busy <= 1'b0;
                        end
                    end else begin
                        r_m <= r_m + 1'b1;
                    end
                end
            end

            if (w_load) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end

            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `BPMU_ASSERT_NOW(a_last_on_scan1, i_clk, i_rst_n, r_out_valid && r_out_last, r_out_row[0])
    `BPMU_ASSERT_NEXT(a_s1_held, i_clk, i_rst_n, r_s1_valid && !w_out_free, r_s1_valid)
    `BPMU_ASSERT_NEXT(a_burst_ends, i_clk, i_rst_n, w_load && w_gen_last, !r_busy)
    `BPMU_ASSERT_NOW(a_pop_idle, i_clk, i_rst_n, o_pop, !w_load)

endmodule

[sim/bgr24_preview_mono_upscale2x_test.sv]
module bgr24_preview_mono_upscale2x_test;
    import bpmu_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } source_pixel_t;

    typedef struct packed {
        logic [15:0] color;
        logic [7:0]  row;
        logic [7:0]  col;
        logic        last;
    } doubled_pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = CFG_THRESHOLD;
    logic [7:0]  cfg_data = 8'd0;
    logic        pix_valid = 1'b0;
    logic [7:0]  pix_blue = 8'd0;
    logic [7:0]  pix_green = 8'd0;
    logic [7:0]  pix_red = 8'd0;
    logic        out_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [15:0] o_pixel_color;
    logic [7:0]  o_out_row;
    logic [7:0]  o_out_col;
    logic        o_last_in_run;

    // source side
    source_pixel_t pixel_q[$];
    int  pixels_sent = 0;
    bit  pix_took = 1'b0;
    int  gap_left = 0;
    int  burst_left = 0;
    int  max_gap = 0;
    int  max_burst = 1;

    // sink side
    int  stall_left = 0;
    int  stall_pct = 0;
    int  max_stall = 1;
    int  hold_asked = 0;
    int  hold_served = 0;

    // shadow of the block
    logic [7:0]     thr_shadow;
    logic           mode_shadow;
    logic [15:0]    chunk_words [CHUNK_PIXELS];
    int             pix_pos;
    int             chunk_col;
    int             src_row;
    doubled_pixel_t doubled_q[$];

    int  mismatches = 0;
    int  cycle_count = 0;

    bgr24_preview_mono_upscale2x DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_valid       (pix_valid),
        .o_ready       (o_ready),
        .i_blue        (pix_blue),
        .i_green       (pix_green),
        .i_red         (pix_red),
        .o_valid       (o_valid),
        .i_ready       (out_ready),
        .o_pixel_color (o_pixel_color),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_last_in_run (o_last_in_run)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, doubled_q.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    function automatic logic [15:0] convert_bgr(input source_pixel_t px, input logic [7:0] thr,
                                                input logic color);
        int luma_sum;
        luma_sum = int'(px.blue) + int'(px.green) + int'(px.red);
        if (color)
            return {px.red[7:3], px.green[7:2], px.blue[7:3]};
        return (luma_sum > 3 * int'(thr)) ? PIX_WHITE : PIX_BLACK;
    endfunction

    // store one source pixel; a full chunk expands into two doubled scanlines
    task automatic take_pixel(input source_pixel_t px);
        doubled_pixel_t d;
        chunk_words[pix_pos] = convert_bgr(px, thr_shadow, mode_shadow);
        if (pix_pos + 1 < CHUNK_PIXELS) begin
            pix_pos++;
            return;
        end
        for (int scan = 0; scan < 2; scan++) begin
            for (int m = 0; m < CHUNK_PIXELS; m++) begin
                for (int copy = 0; copy < 2; copy++) begin
                    d.color = chunk_words[m];
                    d.row   = 8'(src_row * 2 + scan);
                    d.col   = 8'((chunk_col * CHUNK_PIXELS + m) * 2 + copy);
                    d.last  = (scan == 1 && m == CHUNK_PIXELS - 1 && copy == 1);
                    doubled_q.push_back(d);
                end
            end
        end
        pix_pos = 0;
        chunk_col++;
        if (chunk_col >= CHUNKS_PER_ROW) begin
            chunk_col = 0;
            src_row++;
            if (src_row >= IMG_HEIGHT)
                src_row = 0;
        end
    endtask

    task automatic check_output();
        doubled_pixel_t want;
        if (doubled_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result color %h row %0d col %0d last %b",
                                      o_pixel_color, o_out_row, o_out_col, o_last_in_run));
            return;
        end
        want = doubled_q.pop_front();
        if (o_pixel_color !== want.color)
            report_mismatch($sformatf("pixel_color %h, want %h (row %0d col %0d)",
                                      o_pixel_color, want.color, want.row, want.col));
        if (o_out_row !== want.row)
            report_mismatch($sformatf("out_row %0d, want %0d (col %0d)",
                                      o_out_row, want.row, want.col));
        if (o_out_col !== want.col)
            report_mismatch($sformatf("out_col %0d, want %0d (row %0d)",
                                      o_out_col, want.col, want.row));
        if (o_last_in_run !== want.last)
            report_mismatch($sformatf("last_in_run %b, want %b (row %0d col %0d)",
                                      o_last_in_run, want.last, want.row, want.col));
    endtask

    // predict first, so a result on the same edge as its chunk's last pixel still finds it
    always @(posedge clk) begin
        pix_took <= pix_valid && o_ready;
        if (!rst_n) begin
            thr_shadow  = THRESHOLD_RESET;
            mode_shadow = 1'b0;
            pix_pos     = 0;
            chunk_col   = 0;
            src_row     = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_THRESHOLD:  thr_shadow = cfg_data;
                    CFG_COLOR_MODE: mode_shadow = cfg_data[0];
                endcase
            end
            if (pix_valid && o_ready)
                take_pixel('{pix_blue, pix_green, pix_red});
            if (o_valid && out_ready)
                check_output();
        end
    end

    always @(negedge clk) begin
        source_pixel_t px;
        if (!pix_valid || pix_took) begin
            if (gap_left > 0) begin
                gap_left--;
                pix_valid <= 1'b0;
            end else if (rst_n && pixel_q.size() != 0) begin
                px = pixel_q.pop_front();
                pix_blue  <= px.blue;
                pix_green <= px.green;
                pix_red   <= px.red;
                pix_valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(max_burst, 1);
                    gap_left   = $urandom_range(max_gap, 0);
                end
            end else begin
                pix_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            stall_left  = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if ($urandom_range(99, 0) < stall_pct) begin
            stall_left = $urandom_range(max_stall, 1) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic queue_pixel(input source_pixel_t px);
        pixel_q.push_back(px);
        pixels_sent++;
    endtask

    function automatic source_pixel_t pixel_with_sum(input int target);
        source_pixel_t px;
        int s;
        int rest;
        s = (target < 0) ? 0 : (target > 765) ? 765 : target;
        px.blue  = $urandom_range((s < 255) ? s : 255, (s > 510) ? s - 510 : 0);
        rest     = s - int'(px.blue);
        px.green = $urandom_range((rest < 255) ? rest : 255, (rest > 255) ? rest - 255 : 0);
        px.red   = 8'(rest - int'(px.green));
        return px;
    endfunction

    function automatic logic [7:0] corner_byte();
        case ($urandom_range(5, 0))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h07;
            3: return 8'hF8;
            4: return 8'h03;
            default: return 8'hFC;
        endcase
    endfunction

    function automatic source_pixel_t random_pixel(input logic [7:0] thr);
        source_pixel_t px;
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 40) begin
            px = 24'($urandom);
        end else if (pick < 70) begin
            // straddle the mono decision point
            px = pixel_with_sum(3 * int'(thr) + int'($urandom_range(4, 0)) - 2);
        end else if (pick < 85) begin
            px.blue  = corner_byte();
            px.green = corner_byte();
            px.red   = corner_byte();
        end else begin
            px = 24'(1) << $urandom_range(23, 0);
            if ($urandom_range(1, 0))
                px = ~px;
        end
        return px;
    endfunction

    task automatic write_reg(input logic idx, input logic [7:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic set_pace(input int gap, input int burst, input int pct, input int stall);
        max_gap   = gap;
        max_burst = burst;
        stall_pct = pct;
        max_stall = stall;
    endtask

    // wait until every queued pixel is taken and every expected result is out, then let the block settle
    task automatic wait_drained();
        while (pixel_q.size() != 0 || pix_valid || doubled_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        logic [7:0] thr_set;
        logic       mode_set;
        int         n;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        set_pace(2, 6, 20, 3);

        // reset settings: threshold 200, mono; 600 is the decision sum
        queue_pixel('{8'd0, 8'd0, 8'd0});
        queue_pixel('{8'd255, 8'd255, 8'd255});
        queue_pixel('{8'd200, 8'd200, 8'd200});
        queue_pixel('{8'd201, 8'd200, 8'd200});
        queue_pixel('{8'd200, 8'd199, 8'd200});
        queue_pixel('{8'd0, 8'd0, 8'd255});
        queue_pixel('{8'd255, 8'd255, 8'd91});
        queue_pixel('{8'd255, 8'd255, 8'd90});
        for (int k = 0; k < 8; k++)
            queue_pixel(pixel_with_sum(600 + (k & 1)));
        wait_drained();

        // threshold floor: any nonzero sum is white
        write_reg(CFG_THRESHOLD, 8'd0);
        queue_pixel('{8'd0, 8'd0, 8'd0});
        queue_pixel('{8'd1, 8'd0, 8'd0});
        queue_pixel('{8'd0, 8'd1, 8'd0});
        queue_pixel('{8'd0, 8'd0, 8'd128});
        wait_drained();

        // threshold ceiling: even full white stays black
        write_reg(CFG_THRESHOLD, 8'd255);
        queue_pixel('{8'd255, 8'd255, 8'd255});
        queue_pixel('{8'd255, 8'd255, 8'd254});
        wait_drained();

        // color packing, one field at a time and the truncated low bits
        write_reg(CFG_COLOR_MODE, {7'($urandom), 1'b1});
        queue_pixel('{8'hFF, 8'h00, 8'h00});
        queue_pixel('{8'h00, 8'hFF, 8'h00});
        queue_pixel('{8'h00, 8'h00, 8'hFF});
        queue_pixel('{8'h07, 8'h03, 8'h07});
        queue_pixel('{8'hF8, 8'hFC, 8'hF8});
        queue_pixel('{8'h55, 8'hAA, 8'h55});

        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            thr_set  = (ph == 1) ? 8'd0 : (ph == 4) ? 8'd255 : 8'($urandom_range(255, 0));
            mode_set = (ph == 2 || ph == 5);
            write_reg(CFG_THRESHOLD, thr_set);
            write_reg(CFG_COLOR_MODE, {7'($urandom), mode_set});
            if (ph == 0)
                set_pace(0, 1, 0, 1);
            else
                set_pace($urandom_range(8, 1), $urandom_range(20, 1),
                         $urandom_range(60, 10), $urandom_range(6, 1));
            n = 28;
            if (ph == 3) begin
                // sink holds off while the source keeps pushing: both chunk buffers fill
                set_pace(0, 1, stall_pct, max_stall);
                hold_asked++;
                n = 64;
            end
            repeat (n) queue_pixel(random_pixel(thr_set));
        end

        wait_drained();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/bpmu_pkg.sv
rtl/core/bpmu_front.sv
rtl/core/bpmu_queue.sv
rtl/core/bpmu_back.sv
rtl/core/bgr24_preview_mono_upscale2x.sv
sim/bgr24_preview_mono_upscale2x_test.sv
